/* rtl/core/olir_pkg.sv */
// ----------------------------------------------------------------------------
// olir_pkg
// Shared types and constants for the ordered list insert/remove core.
// ----------------------------------------------------------------------------
package olir_pkg;

  // Default geometry
  localparam int unsigned ListDepth = 16;
  localparam int unsigned ValueBits = 8;

  // Fixed item field widths
  localparam int unsigned OperandBits = 8;
  localparam int unsigned CountBits   = 5;

  // Position and count travel to the cells at a width that covers the
  // largest supported depth (256 entries, count up to 256).
  localparam int unsigned CtrlBits = 9;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } olir_cmd_e;

  typedef enum logic {
    StatusOk   = 1'b0,
    StatusFail = 1'b1
  } olir_status_e;

  typedef struct packed {
    olir_cmd_e              command;
    logic [OperandBits-1:0] operand_value;
    logic [OperandBits-1:0] new_width;
    logic [OperandBits-1:0] new_height;
  } olir_req_t;

  typedef struct packed {
    olir_status_e         status;
    logic [CountBits-1:0] entry_count;
  } olir_rsp_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                ins_en;
    logic                rem_en;
    logic [CtrlBits-1:0] pos;
    logic [CtrlBits-1:0] count;
  } olir_ctrl_t;

endpackage

/* rtl/core/olir_if.sv */
// ----------------------------------------------------------------------------
// olir_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface olir_req_if;
  import olir_pkg::*;

  logic      valid;
  logic      ready;
  olir_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface olir_rsp_if;
  import olir_pkg::*;

  logic      valid;
  logic      ready;
  olir_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/olir_cell.sv */
// ----------------------------------------------------------------------------
// olir_cell
// One list slot: holds an entry, matches the key, shifts with its neighbors.
// ----------------------------------------------------------------------------
module olir_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned VALUE_BITS = olir_pkg::ValueBits
) (
  input  logic                   clk_i,
  input  olir_pkg::olir_ctrl_t   ctrl_i,
  input  logic [VALUE_BITS-1:0]  key_i,
  input  logic [VALUE_BITS-1:0]  new_w_i,
  input  logic [VALUE_BITS-1:0]  new_h_i,
  input  logic [VALUE_BITS-1:0]  left_w_i,
  input  logic [VALUE_BITS-1:0]  left_h_i,
  input  logic [VALUE_BITS-1:0]  right_w_i,
  input  logic [VALUE_BITS-1:0]  right_h_i,
  input  logic                   hit_i,
  output logic                   hit_o,
  output logic [VALUE_BITS-1:0]  w_o,
  output logic [VALUE_BITS-1:0]  h_o
);
  import olir_pkg::*;

  localparam logic [CtrlBits-1:0] SlotIdx = CtrlBits'(IDX);

  logic [VALUE_BITS-1:0] w_q, w_d;
  logic [VALUE_BITS-1:0] h_q, h_d;
  logic                  in_list;
  logic                  match;

  assign in_list = SlotIdx < ctrl_i.count;
  assign match   = ctrl_i.rem_en && in_list && (w_q == key_i);
  assign hit_o   = hit_i | match;

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (ctrl_i.ins_en) begin
      if (SlotIdx > ctrl_i.pos) begin
        w_d = left_w_i;
        h_d = left_h_i;
      end else if (SlotIdx == ctrl_i.pos) begin
        w_d = new_w_i;
        h_d = new_h_i;
      end
    end else if (hit_o) begin
      // close the gap: pull the entry behind this slot forward
      w_d = right_w_i;
      h_d = right_h_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    h_q <= h_d;
  end

  assign w_o = w_q;
  assign h_o = h_q;

endmodule

/* rtl/core/ordered_list_insert_remove_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_core
// Bounded ordered list with insert-at-position and remove-first-by-width.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries command items (insert at position / remove by width key)
//   with the entry width and height for inserts. rsp_o returns one item per
//   command: success or failure and the entry count after the command.
//   The list is a row of LIST_DEPTH cells. On an insert every cell compares
//   its slot index against the position and either holds, loads the new
//   entry, or takes its left neighbor's entry. On a remove every cell
//   compares its width with the key; a hit flag ripples down the row so that
//   the first match and every cell after it take the right neighbor's entry.
//   Throughput: one item per cycle while rsp_o.ready is high. A command is
//   executed in the cycle it is accepted; its result sits in the output
//   register the next cycle. The cell row and count register form the loop.
//   Stall: while a result waits and rsp_o.ready is low, req_i.ready drops;
//   when the result is taken the next item is accepted in that same cycle.
//   Reset: the entry count and the result valid flag clear; the cell
//   contents are not reset and are never read before being written.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_core #(
  parameter int unsigned LIST_DEPTH = olir_pkg::ListDepth,
  parameter int unsigned VALUE_BITS = olir_pkg::ValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  olir_req_if.sink          req_i,
  olir_rsp_if.source        rsp_o
);
  import olir_pkg::*;

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam logic [CtrlBits-1:0] DepthLim = CtrlBits'(LIST_DEPTH);

  // Count of held entries
  logic [CntW-1:0]     count_q, count_d;
  logic [CtrlBits-1:0] count_wide;
  logic [CtrlBits-1:0] count_next_wide;

  // Result register
  logic                 rsp_valid_q, rsp_valid_d;
  olir_rsp_t            rsp_q, rsp_d;

  logic                 accept;
  logic                 is_insert;
  logic                 ins_ok;
  logic                 removed;
  logic [CtrlBits-1:0]  pos_wide;
  logic [31:0]          key_wide, new_w_wide, new_h_wide;
  logic [VALUE_BITS-1:0] key, new_w, new_h;
  olir_ctrl_t           ctrl;

  // Cell row wiring
  logic [VALUE_BITS-1:0] cell_w [LIST_DEPTH];
  logic [VALUE_BITS-1:0] cell_h [LIST_DEPTH];
  logic [LIST_DEPTH:0]   hit_chain;

  // Accept a new item whenever the result slot is empty or being drained
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign count_wide = CtrlBits'(count_q);
  assign pos_wide   = CtrlBits'(req_i.data.operand_value);
  assign is_insert  = (req_i.data.command == CmdInsert);

  // Insert fails on a full list or a position past the tail
  assign ins_ok = (count_wide < DepthLim) && (pos_wide <= count_wide);

  // Entry values and the key are taken modulo 2^VALUE_BITS
  assign key_wide   = 32'(req_i.data.operand_value);
  assign new_w_wide = 32'(req_i.data.new_width);
  assign new_h_wide = 32'(req_i.data.new_height);
  assign key        = key_wide[VALUE_BITS-1:0];
  assign new_w      = new_w_wide[VALUE_BITS-1:0];
  assign new_h      = new_h_wide[VALUE_BITS-1:0];

  always_comb begin
    ctrl.ins_en = accept && is_insert && ins_ok;
    ctrl.rem_en = accept && !is_insert;
    ctrl.pos    = pos_wide;
    ctrl.count  = count_wide;
  end

  // The hit flag enters the row clear and leaves it set on any match
  assign hit_chain[0] = 1'b0;
  assign removed      = hit_chain[LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_w, left_h, right_w, right_h;

    if (i == 0) begin : g_head
      // never shifts right into the head; feed the new entry
      assign left_w = new_w;
      assign left_h = new_h;
    end else begin : g_body
      assign left_w = cell_w[i-1];
      assign left_h = cell_h[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      // the slot vacated at the tail is past the count; keep its contents
      assign right_w = cell_w[i];
      assign right_h = cell_h[i];
    end else begin : g_inner
      assign right_w = cell_w[i+1];
      assign right_h = cell_h[i+1];
    end

    olir_cell #(
      .IDX        (i),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .key_i     (key),
      .new_w_i   (new_w),
      .new_h_i   (new_h),
      .left_w_i  (left_w),
      .left_h_i  (left_h),
      .right_w_i (right_w),
      .right_h_i (right_h),
      .hit_i     (hit_chain[i]),
      .hit_o     (hit_chain[i+1]),
      .w_o       (cell_w[i]),
      .h_o       (cell_h[i])
    );
  end

  // Count update and result formation
  always_comb begin
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;

    if (ctrl.ins_en) begin
      count_d = count_q + CntW'(1);
    end else if (removed) begin
      count_d = count_q - CntW'(1);
    end

    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    if (accept) begin
      rsp_valid_d = 1'b1;
      if (is_insert) begin
        rsp_d.status = ins_ok ? StatusOk : StatusFail;
      end else begin
        rsp_d.status = removed ? StatusOk : StatusFail;
      end
      rsp_d.entry_count = count_next_wide[CountBits-1:0];
    end
  end

  assign count_next_wide = CtrlBits'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Hold the result payload; no reset needed
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule
